FILE: hw/rtl/bfb_pkg.sv
// Shared types and constants for the bit-plane frame buffer.
// Depends on nothing; used by bitplane_frame_buffer_unit.
`timescale 1ns / 1ps

package bfb_pkg;

  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;

  localparam logic [7:0] COLUMNS_RST = 8'd128;
  localparam logic [6:0] ROWS_RST    = 7'd64;

  localparam logic [1:0] ACT_WRITE_POINT = 2'd0;
  localparam logic [1:0] ACT_READ_POINT  = 2'd1;
  localparam logic [1:0] ACT_RECT_FILL   = 2'd2;
  localparam logic [1:0] ACT_CLEAR       = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic       pixel_value;
  } in_item_t;

  typedef struct packed {
    logic read_pixel;
    logic in_range;
  } out_item_t;

endpackage

FILE: hw/rtl/bfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/bitplane_frame_buffer_unit.sv
// Top level of the bit-plane frame buffer: sequencer, config registers, shared multiplier.
// Depends on bfb_pkg and bfb_ram.
`timescale 1ns / 1ps

// One-bit-per-pixel frame buffer, column-major, MSB-first inside each byte.
// Byte address of pixel (x, y) is x*rows/8 + y/8 over the configured rows.
// Input: a beat is taken when start is high and busy is low; busy stays high
//   until the item's result has been issued; an empty rect fill never raises it.
// Output: one result beat per item, out_strobe high for exactly one cycle;
//   the receiver cannot stall, so nothing is held back.
// Config: cfg_we writes register cfg_index (0 columns, 1 rows) at once;
//   only change it while busy is low and no result is pending.
// Steps per item (the next item may be taken in the strobe cycle):
//   write / read point: address step, RAM read, modify/write, then the strobe.
//   point outside the area: it ends after the address step.
//   rect fill: address, RAM read, modify/write for each pixel inside the configured area.
//   clear: a setup step, then one byte per step over the columns*rows/8 bytes.
// The 8x7 multiplier is shared for pixel addresses and the clear length, and
// the single RAM write port sets one byte per cycle at most.
// Reset: the store is swept to zero, one byte a cycle, over all MAX_COLUMNS*MAX_ROWS/8
//   bytes (rounded up); busy is high and no item is taken meanwhile.
module bitplane_frame_buffer_unit import bfb_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_strobe,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int STORE_BYTES = (MAX_COLUMNS * MAX_ROWS + 7) / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CNT_W       = $clog2(STORE_BYTES + 1);
  localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(STORE_BYTES - 1);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_ADDR   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_WRITE  = 7'b0010000,
    S_CSETUP = 7'b0100000,
    S_CLEAR  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [7:0]          cols_r, cols_nxt;
  logic [6:0]          rows_r, rows_nxt;
  logic [1:0]          act_r, act_nxt;
  logic [7:0]          x_r, x_nxt;
  logic [7:0]          y_r, y_nxt;
  logic [7:0]          ys_r, ys_nxt;
  logic [7:0]          xlast_r, xlast_nxt;
  logic [7:0]          ylast_r, ylast_nxt;
  logic                pv_r, pv_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    lim_r, lim_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  out_item_t           out_item_r, out_item_nxt;

  // effective area, registers clamped to the store size
  logic [7:0]  c_eff;
  logic [7:0]  r_eff8;
  logic [6:0]  r_eff;
  logic [7:0]  mul_a;
  logic [14:0] prod;
  logic [14:0] prod_div8;
  logic        pt_ok;
  logic        rect_empty;
  logic [7:0]  xlast_in, ylast_in;
  logic [7:0]  pix_mask;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  assign c_eff  = (cols_r > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : cols_r;
  assign r_eff8 = ({1'b0, rows_r} > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : {1'b0, rows_r};
  assign r_eff  = r_eff8[6:0];

  // shared multiplier: pixel column times rows, or columns times rows for clear
  assign mul_a     = (state_r == S_CSETUP) ? c_eff : x_r;
  assign prod      = {7'b0, mul_a} * {8'b0, r_eff};
  assign prod_div8 = prod >> 3;

  assign pt_ok    = (x_r < c_eff) && (y_r < r_eff8);
  assign pix_mask = 8'h80 >> y_r[2:0];

  // rectangle clipped to the area at accept time
  assign xlast_in   = (in_item.x_end < c_eff) ? in_item.x_end : c_eff - 8'd1;
  assign ylast_in   = (in_item.y_end < r_eff8) ? in_item.y_end : r_eff8 - 8'd1;
  assign rect_empty = (c_eff == 8'd0) || (r_eff8 == 8'd0) ||
                      (in_item.x_start > xlast_in) || (in_item.y_start > ylast_in);

  always_comb begin
    state_nxt      = state_r;
    cols_nxt       = cols_r;
    rows_nxt       = rows_r;
    act_nxt        = act_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    ys_nxt         = ys_r;
    xlast_nxt      = xlast_r;
    ylast_nxt      = ylast_r;
    pv_nxt         = pv_r;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;
    lim_nxt        = lim_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = 8'h00;
    ram_re         = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMNS: cols_nxt = cfg_wdata[7:0];
        REG_ROWS:    rows_nxt = cfg_wdata[6:0];
        default:     ;
      endcase
    end

    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[ADDR_W-1:0];
        if (cnt_r == LAST_BYTE) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          act_nxt   = in_item.action;
          x_nxt     = in_item.x_start;
          y_nxt     = in_item.y_start;
          ys_nxt    = in_item.y_start;
          xlast_nxt = xlast_in;
          ylast_nxt = ylast_in;
          pv_nxt    = in_item.pixel_value;
          unique case (in_item.action)
            ACT_WRITE_POINT, ACT_READ_POINT: state_nxt = S_ADDR;
            ACT_RECT_FILL: begin
              if (rect_empty) begin
                out_strobe_nxt = 1'b1;
                out_item_nxt   = '{read_pixel: 1'b0, in_range: 1'b1};
              end else begin
                state_nxt = S_ADDR;
              end
            end
            ACT_CLEAR: state_nxt = S_CSETUP;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADDR: begin
        addr_nxt = ADDR_W'(prod_div8 + {7'b0, y_r >> 3});
        if (act_r != ACT_RECT_FILL && !pt_ok) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '{read_pixel: 1'b0, in_range: 1'b0};
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (act_r == ACT_READ_POINT) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '{read_pixel: |(ram_rdata & pix_mask), in_range: 1'b1};
          state_nxt      = S_IDLE;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = pv_r ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
          if (act_r == ACT_WRITE_POINT) begin
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '{read_pixel: 1'b0, in_range: 1'b1};
            state_nxt      = S_IDLE;
          end else if (y_r != ylast_r) begin
            y_nxt     = y_r + 8'd1;
            state_nxt = S_ADDR;
          end else if (x_r != xlast_r) begin
            x_nxt     = x_r + 8'd1;
            y_nxt     = ys_r;
            state_nxt = S_ADDR;
          end else begin
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '{read_pixel: 1'b0, in_range: 1'b1};
            state_nxt      = S_IDLE;
          end
        end
      end
      S_CSETUP: begin
        lim_nxt   = CNT_W'(prod_div8);
        cnt_nxt   = '0;
        state_nxt = S_CLEAR;
      end
      S_CLEAR: begin
        if (cnt_r == lim_r) begin
          cnt_nxt        = '0;
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '{read_pixel: 1'b0, in_range: 1'b1};
          state_nxt      = S_IDLE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r[ADDR_W-1:0];
          cnt_nxt   = cnt_r + CNT_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cols_r       <= COLUMNS_RST;
      rows_r       <= ROWS_RST;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cols_r       <= cols_nxt;
      rows_r       <= rows_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    ys_r       <= ys_nxt;
    xlast_r    <= xlast_nxt;
    ylast_r    <= ylast_nxt;
    pv_r       <= pv_nxt;
    addr_r     <= addr_nxt;
    lim_r      <= lim_nxt;
    out_item_r <= out_item_nxt;
  end

  bfb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef NO_ASSERTIONS
  a_no_pixel_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_item.read_pixel && !out_item.in_range))
    else $error("read_pixel set for an out-of-area point");

  a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (32'(ram_waddr) < STORE_BYTES))
    else $error("store write beyond its depth");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we && !ram_re)
    else $error("store access while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.action != ACT_RECT_FILL) |=> busy && !out_strobe)
    else $error("item accepted but sequencer did not start");

  a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> (state_r == S_WRITE))
    else $error("read data not consumed by modify step");
`endif

endmodule

FILE: dv/bitplane_frame_buffer_unit_test.sv
// Self-checking bench for bitplane_frame_buffer_unit: a directed table, then random
// phases over several column/row settings, each result beat checked in order.
// Depends on bfb_pkg and the frame buffer RTL.
`timescale 1ns / 1ps

module bitplane_frame_buffer_unit_test import bfb_pkg::*;;

  localparam int MAX_COLS    = DEF_MAX_COLUMNS;
  localparam int MAX_ROWS_P  = DEF_MAX_ROWS;
  localparam int STORE_BYTES = (MAX_COLS * MAX_ROWS_P + 7) / 8;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 240;
  // Slowest single item is a full-area rect fill, slower than the reset sweep.
  // STALL_LIMIT allows about four times that worst case.
  localparam int STALL_LIMIT = 100000;
  localparam int TAIL_CYCLES = 16;
  localparam bit TYPED       = 1'b1;
  localparam bit PREDICTED   = 1'b0;

  // One row of the directed table: either a register write or an item.
  // When has_known is set, the expected beat is the one typed into the row.
  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [7:0]           reg_val;
    in_item_t             item;
    logic                 has_known;
    out_item_t            known;
  } vector_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_strobe;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the pixel store and of the two registers.
  logic [7:0] shadow_store [STORE_BYTES];
  logic [7:0] shadow_cols;
  logic [6:0] shadow_rows;

  out_item_t  pending_results [$];
  out_item_t  oldest_result;
  int         mismatches;
  int         stall_cycles;
  logic [7:0] last_x;
  logic [7:0] last_y;

  always #2 clk = ~clk;

  bitplane_frame_buffer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Registers above the build limits act as the limit.
  function automatic int eff_columns();
    return (int'(shadow_cols) > MAX_COLS) ? MAX_COLS : int'(shadow_cols);
  endfunction

  function automatic int eff_rows();
    return (int'(shadow_rows) > MAX_ROWS_P) ? MAX_ROWS_P : int'(shadow_rows);
  endfunction

  // Column-major byte address, MSB-first bit. Rows not a multiple of eight
  // round the address down, so neighbor columns can share a byte.
  function automatic bit locate_pixel(input int x, input int y,
                                      output int addr, output logic [7:0] mask);
    int c;
    int r;
    c    = eff_columns();
    r    = eff_rows();
    addr = 0;
    mask = '0;
    if (x >= c || y >= r) return 1'b0;
    addr = x * r / 8 + y / 8;
    if (addr >= STORE_BYTES) return 1'b0;
    mask = 8'h80 >> (y % 8);
    return 1'b1;
  endfunction

  function automatic void paint(int addr, logic [7:0] mask, logic value);
    shadow_store[addr] = value ? (shadow_store[addr] | mask) : (shadow_store[addr] & ~mask);
  endfunction

  // Applies one item to the shadow store and returns its result beat.
  function automatic out_item_t predict_pixel_result(in_item_t it);
    out_item_t  res;
    int         addr;
    int         x;
    int         y;
    int         n;
    logic [7:0] mask;
    res.read_pixel = 1'b0;
    res.in_range   = 1'b1;
    case (it.action)
      ACT_WRITE_POINT: begin
        if (locate_pixel(it.x_start, it.y_start, addr, mask)) begin
          paint(addr, mask, it.pixel_value);
        end else begin
          res.in_range = 1'b0;
        end
      end
      ACT_READ_POINT: begin
        if (locate_pixel(it.x_start, it.y_start, addr, mask)) begin
          res.read_pixel = |(shadow_store[addr] & mask);
        end else begin
          res.in_range = 1'b0;
        end
      end
      ACT_RECT_FILL: begin
        // Inclusive bounds; start past end gives an empty rectangle.
        for (x = it.x_start; x <= int'(it.x_end); x++) begin
          for (y = it.y_start; y <= int'(it.y_end); y++) begin
            if (locate_pixel(x, y, addr, mask)) paint(addr, mask, it.pixel_value);
          end
        end
      end
      default: begin
        n = eff_columns() * eff_rows() / 8;
        if (n > STORE_BYTES) n = STORE_BYTES;
        for (x = 0; x < n; x++) shadow_store[x] = 8'h00;
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic vector_t op_row(logic [1:0] act, int xs, int ys, int xe, int ye,
                                     bit pv, bit has_known, bit rd, bit ok);
    vector_t v;
    v                     = '0;
    v.item.action         = act;
    v.item.x_start        = 8'(xs);
    v.item.y_start        = 8'(ys);
    v.item.x_end          = 8'(xe);
    v.item.y_end          = 8'(ye);
    v.item.pixel_value    = pv;
    v.has_known           = has_known;
    v.known.read_pixel    = rd;
    v.known.in_range      = ok;
    return v;
  endfunction

  function automatic vector_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    vector_t v;
    v         = '0;
    v.is_reg  = 1'b1;
    v.reg_idx = idx;
    v.reg_val = val;
    return v;
  endfunction

  // Mostly inside the area, sometimes right on or past the edge, now and
  // then anywhere in the 8-bit range.
  function automatic logic [7:0] random_coord(int span);
    int roll;
    roll = $urandom_range(0, 19);
    if (span == 0 || roll == 0) return 8'($urandom_range(0, 255));
    if (roll == 1) return 8'(span);
    if (roll == 2) return 8'(span - 1);
    return 8'($urandom_range(0, span - 1));
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       roll;
    int       c;
    int       r;
    int       ends;
    c              = eff_columns();
    r              = eff_rows();
    // Unused fields carry noise.
    it.x_start     = 8'($urandom);
    it.y_start     = 8'($urandom);
    it.x_end       = 8'($urandom);
    it.y_end       = 8'($urandom);
    it.pixel_value = 1'($urandom);
    roll           = $urandom_range(0, 99);
    if (roll < 38) begin
      it.action  = ACT_WRITE_POINT;
      it.x_start = random_coord(c);
      it.y_start = random_coord(r);
      last_x     = it.x_start;
      last_y     = it.y_start;
    end else if (roll < 76) begin
      it.action = ACT_READ_POINT;
      // Read back recent writes often so set bits are actually seen.
      if ($urandom_range(0, 2) == 0) begin
        it.x_start = last_x;
        it.y_start = last_y;
      end else begin
        it.x_start = random_coord(c);
        it.y_start = random_coord(r);
      end
    end else if (roll < 94) begin
      it.action  = ACT_RECT_FILL;
      it.x_start = random_coord(c);
      it.y_start = random_coord(r);
      roll       = $urandom_range(0, 49);
      if (roll == 0) begin
        // Keep the random ends: occasionally a large walk.
      end else if (roll < 5 && it.x_start != 8'd0) begin
        it.x_end = it.x_start - 8'd1;
      end else begin
        ends     = int'(it.x_start) + $urandom_range(0, 6);
        it.x_end = 8'((ends > 255) ? 255 : ends);
        ends     = int'(it.y_start) + $urandom_range(0, 9);
        it.y_end = 8'((ends > 255) ? 255 : ends);
      end
    end else begin
      it.action = ACT_CLEAR;
    end
    return it;
  endfunction

  // Hold the sender until every expected beat has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_COLUMNS) begin
      shadow_cols = val;
    end else begin
      shadow_rows = val[6:0];
    end
  endtask

  // Drive one item and hold it until the block takes it. busy is sampled
  // before the edge's updates land, so this is the value that decided the beat.
  task automatic send_item(in_item_t it, bit has_known, out_item_t known);
    out_item_t predicted;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = predict_pixel_result(it);
    pending_results.push_back(has_known ? known : predicted);
  endtask

  // ---------------------------------------------------------------------------
  // Result check: one strobe, one beat, always against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got read_pixel=%0b in_range=%0b",
                 $time, out_item.read_pixel, out_item.in_range);
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_item.read_pixel !== oldest_result.read_pixel ||
            out_item.in_range !== oldest_result.in_range) begin
          $display("%0t ns: mismatch, expected read_pixel=%0b in_range=%0b, got %0b %0b",
                   $time, oldest_result.read_pixel, oldest_result.in_range,
                   out_item.read_pixel, out_item.in_range);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles with neither an input beat nor a result beat.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("bitplane_frame_buffer_unit_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    vector_t    directed_vectors [$];
    vector_t    v;
    logic [7:0] cols_val;
    logic [7:0] rows_val;
    int         ph;
    int         n;
    int         idle_odds;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_COLUMNS;
    cfg_wdata    = '0;
    mismatches   = 0;
    stall_cycles = 0;
    last_x       = '0;
    last_y       = '0;
    shadow_cols  = COLUMNS_RST;
    shadow_rows  = ROWS_RST;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;

    // Reset defaults (128 x 64): corners, out-of-area points, full and empty
    // rectangles, clear with noise in the unused fields.
    directed_vectors.push_back(op_row(ACT_READ_POINT, 0, 0, 0, 0, 0, TYPED, 0, 1));
    directed_vectors.push_back(op_row(ACT_READ_POINT, 127, 63, 255, 255, 1, TYPED, 0, 1));
    directed_vectors.push_back(op_row(ACT_WRITE_POINT, 127, 63, 255, 255, 1, TYPED, 0, 1));
    directed_vectors.push_back(op_row(ACT_READ_POINT, 127, 63, 0, 0, 0, TYPED, 1, 1));
    directed_vectors.push_back(op_row(ACT_WRITE_POINT, 127, 63, 255, 255, 0, TYPED, 0, 1));
    directed_vectors.push_back(op_row(ACT_WRITE_POINT, 128, 0, 0, 0, 1, TYPED, 0, 0));
    directed_vectors.push_back(op_row(ACT_READ_POINT, 0, 64, 0, 0, 1, TYPED, 0, 0));
    directed_vectors.push_back(op_row(ACT_RECT_FILL, 0, 0, 255, 255, 1, TYPED, 0, 1));
    directed_vectors.push_back(op_row(ACT_READ_POINT, 64, 31, 0, 0, 0, TYPED, 1, 1));
    directed_vectors.push_back(op_row(ACT_RECT_FILL, 10, 0, 5, 255, 0, TYPED, 0, 1));
    directed_vectors.push_back(op_row(ACT_RECT_FILL, 0, 200, 255, 100, 0, TYPED, 0, 1));
    directed_vectors.push_back(op_row(ACT_READ_POINT, 0, 0, 0, 0, 0, TYPED, 1, 1));
    directed_vectors.push_back(op_row(ACT_RECT_FILL, 2, 3, 4, 9, 0, PREDICTED, 0, 0));
    directed_vectors.push_back(op_row(ACT_READ_POINT, 3, 5, 0, 0, 1, PREDICTED, 0, 0));
    directed_vectors.push_back(op_row(ACT_CLEAR, 255, 255, 255, 255, 1, TYPED, 0, 1));
    directed_vectors.push_back(op_row(ACT_READ_POINT, 127, 63, 0, 0, 0, TYPED, 0, 1));
    // Columns above the limit, rows not a multiple of eight: shared bytes.
    directed_vectors.push_back(reg_row(REG_COLUMNS, 8'd255));
    directed_vectors.push_back(reg_row(REG_ROWS, 8'd5));
    directed_vectors.push_back(op_row(ACT_WRITE_POINT, 1, 3, 0, 0, 1, PREDICTED, 0, 0));
    directed_vectors.push_back(op_row(ACT_READ_POINT, 0, 3, 0, 0, 0, PREDICTED, 0, 0));
    directed_vectors.push_back(op_row(ACT_WRITE_POINT, 127, 4, 0, 0, 1, PREDICTED, 0, 0));
    directed_vectors.push_back(op_row(ACT_CLEAR, 0, 0, 0, 0, 0, TYPED, 0, 1));
    directed_vectors.push_back(op_row(ACT_READ_POINT, 1, 3, 0, 0, 0, PREDICTED, 0, 0));
    // Both registers at zero (rows written with only bit 7 set): empty area.
    directed_vectors.push_back(reg_row(REG_COLUMNS, 8'd0));
    directed_vectors.push_back(reg_row(REG_ROWS, 8'h80));
    directed_vectors.push_back(op_row(ACT_READ_POINT, 0, 0, 0, 0, 0, TYPED, 0, 0));
    directed_vectors.push_back(op_row(ACT_WRITE_POINT, 0, 0, 0, 0, 1, TYPED, 0, 0));
    directed_vectors.push_back(op_row(ACT_RECT_FILL, 0, 0, 255, 255, 1, TYPED, 0, 1));
    directed_vectors.push_back(op_row(ACT_CLEAR, 0, 0, 0, 0, 0, TYPED, 0, 1));
    // Smallest area, a single pixel.
    directed_vectors.push_back(reg_row(REG_COLUMNS, 8'd1));
    directed_vectors.push_back(reg_row(REG_ROWS, 8'd1));
    directed_vectors.push_back(op_row(ACT_WRITE_POINT, 0, 0, 0, 0, 1, TYPED, 0, 1));
    directed_vectors.push_back(op_row(ACT_READ_POINT, 0, 0, 0, 0, 0, PREDICTED, 0, 0));
    directed_vectors.push_back(op_row(ACT_READ_POINT, 1, 0, 0, 0, 1, TYPED, 0, 0));

    // Hold the synchronous reset, then release it; the block sweeps its store with
    // busy high, which send_item simply waits out.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_vectors[i]) begin
      v = directed_vectors[i];
      if (v.is_reg) begin
        write_reg(v.reg_idx, v.reg_val);
      end else begin
        send_item(v.item, v.has_known, v.known);
      end
    end

    // Random phases, each with its own area. Registers change only once the
    // block has gone idle; the last phase runs back to back with no gaps.
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          cols_val = 8'd128;
          rows_val = 8'd64;
        end
        1: begin
          cols_val = 8'd255;
          rows_val = 8'hFF;
        end
        2: begin
          cols_val = 8'd1;
          rows_val = 8'd1;
        end
        3: begin
          cols_val = 8'($urandom_range(1, 128));
          rows_val = 8'($urandom_range(1, 64));
        end
        4: begin
          cols_val = 8'($urandom_range(1, 255));
          rows_val = 8'($urandom);
        end
        5: begin
          cols_val = 8'd8;
          rows_val = 8'd8;
        end
        6: begin
          cols_val = 8'($urandom_range(1, 128));
          rows_val = 8'($urandom_range(1, 63));
        end
        default: begin
          cols_val = 8'd128;
          rows_val = 8'd64;
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_COLUMNS, cols_val);
        write_reg(REG_ROWS, rows_val);
      end else begin
        write_reg(REG_ROWS, rows_val);
        write_reg(REG_COLUMNS, cols_val);
      end

      idle_odds = (ph % 2 == 0) ? 3 : 8;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph != N_PHASES - 1 && $urandom_range(1, idle_odds) == 1) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        // Mid-phase pause with the pipe fully drained.
        if (ph == 3 && n == PHASE_ITEMS / 2) drain_results();
        send_item(random_item(), PREDICTED, '0);
      end
    end

    // Let every beat come home, then keep watching for stray beats.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("bitplane_frame_buffer_unit_test passed");
    end else begin
      $display("bitplane_frame_buffer_unit_test failed");
    end
    $finish;
  end

endmodule
